[rtl/vector2_normalize_defines.svh]
// Assertion helpers used by vector2_normalize.sv.
`ifndef VECTOR2_NORMALIZE_DEFINES_SVH
`define VECTOR2_NORMALIZE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define VN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector2_normalize assertion failed");

// Next-cycle implication, disabled while reset is held.
`define VN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vector2_normalize assertion failed");

`endif

[rtl/vn_pkg.sv]
`default_nettype none
package vn_pkg;
  localparam int COMP_BITS = 32;
  localparam int FRAC_OUT  = 30;
  localparam int OUT_W     = 32;
  localparam int SQ_W      = 2 * COMP_BITS;
  localparam int LEN_W     = COMP_BITS;
  localparam int REM_W     = LEN_W + 2;
  localparam int DR_W      = LEN_W + 1;
  localparam int Q_W       = FRAC_OUT + 1;

  // Sign and magnitude of both components, carried alongside the root.
  typedef struct packed {
    logic             nx;
    logic             ny;
    logic [LEN_W-1:0] mx;
    logic [LEN_W-1:0] my;
  } carry_t;

  typedef struct packed {
    logic [SQ_W-1:0]  s;
    logic [REM_W-1:0] rem;
    logic [LEN_W-1:0] root;
    carry_t           c;
  } sq_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [DR_W-1:0]  rx;
    logic [DR_W-1:0]  ry;
    logic [Q_W-1:0]   qx;
    logic [Q_W-1:0]   qy;
    logic             nx;
    logic             ny;
  } dv_t;
endpackage
`default_nettype wire

[rtl/vn_sqrt_cell.sv]
`default_nettype none
module vn_sqrt_cell (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic       i_valid,
  input  wire vn_pkg::sq_t i_st,
  output logic            o_valid,
  output vn_pkg::sq_t     o_st
);
  import vn_pkg::*;

  logic [REM_W:0]   rem_sh;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             ge;
  sq_t              st_nxt;
  sq_t              st_r;
  logic             valid_r;

  // One root bit per cell: bring down the next two bits of the operand.
  always_comb begin
    rem_sh = (REM_W+1)'({i_st.rem, i_st.s[SQ_W-1 -: 2]});
    trial  = (REM_W+1)'({i_st.root, 2'b01});
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
    st_nxt.s    = {i_st.s[SQ_W-3:0], 2'b00};
    st_nxt.rem  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    st_nxt.root = {i_st.root[LEN_W-2:0], ge};
    st_nxt.c    = i_st.c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_st    = st_r;
endmodule
`default_nettype wire

[rtl/vn_div_cell.sv]
`default_nettype none
module vn_div_cell (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        i_valid,
  input  wire vn_pkg::dv_t i_st,
  output logic             o_valid,
  output vn_pkg::dv_t      o_st
);
  import vn_pkg::*;

  logic [DR_W-1:0] len_ext;
  logic [DR_W-1:0] dx;
  logic [DR_W-1:0] dy;
  logic [DR_W-1:0] kx;
  logic [DR_W-1:0] ky;
  logic            gx;
  logic            gy;
  dv_t             st_nxt;
  dv_t             st_r;
  logic            valid_r;

  // One quotient bit per cell for each component, restoring division.
  always_comb begin
    len_ext = {1'b0, i_st.len};
    gx = i_st.rx >= len_ext;
    gy = i_st.ry >= len_ext;
    dx = i_st.rx - len_ext;
    dy = i_st.ry - len_ext;
    kx = gx ? dx : i_st.rx;
    ky = gy ? dy : i_st.ry;
    st_nxt     = i_st;
    st_nxt.rx  = {kx[DR_W-2:0], 1'b0};
    st_nxt.ry  = {ky[DR_W-2:0], 1'b0};
    st_nxt.qx  = {i_st.qx[Q_W-2:0], gx};
    st_nxt.qy  = {i_st.qy[Q_W-2:0], gy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_st    = st_r;
endmodule
`default_nettype wire

[rtl/vector2_normalize.sv]
// Throughput: one vector per cycle unless the output stalls.
// The square-root and divider cell rows advance together.
// A stall at the output holds the whole row of cells; no bubbles are squeezed out.
// Reset (rst_n low, synchronous) clears all valid bits; no clearing pass is needed.
`default_nettype none
`include "vector2_normalize_defines.svh"
module vector2_normalize (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [2*vn_pkg::OUT_W-1:0] in_tdata,  // comp_x, comp_y
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [2*vn_pkg::OUT_W-1:0]   out_tdata,    // unit_x, unit_y
  output logic                         out_tuser     // zero_length
);
  import vn_pkg::*;

  logic                 adv;
  logic [LEN_W-1:0]     vx;
  logic [LEN_W-1:0]     vy;
  carry_t               c_nxt;
  carry_t               c0_r;
  carry_t               c1_r;
  carry_t               c2_r;
  logic                 v0_r;
  logic                 v1_r;
  logic                 v2_r;
  logic [SQ_W-1:0]      sqx_r;
  logic [SQ_W-1:0]      sqy_r;
  logic [SQ_W-1:0]      sum_r;
  sq_t                  sq_st [0:LEN_W];
  logic                 sq_v  [0:LEN_W];
  dv_t                  dv_st [0:Q_W];
  logic                 dv_v  [0:Q_W];
  logic [OUT_W-1:0]     qx_ext;
  logic [OUT_W-1:0]     qy_ext;
  logic                 zero_len;
  logic [OUT_W-1:0]     ux_nxt;
  logic [OUT_W-1:0]     uy_nxt;
  logic                 out_valid_r;
  logic [OUT_W-1:0]     ux_r;
  logic [OUT_W-1:0]     uy_r;
  logic                 zl_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // Sign and magnitude; the most negative value maps to 2^(COMP_BITS-1).
  always_comb begin
    vx = in_tdata[COMP_BITS-1:0];
    vy = in_tdata[OUT_W +: COMP_BITS];
    c_nxt.nx = vx[LEN_W-1];
    c_nxt.ny = vy[LEN_W-1];
    c_nxt.mx = c_nxt.nx ? (~vx + 1'b1) : vx;
    c_nxt.my = c_nxt.ny ? (~vy + 1'b1) : vy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0_r  <= c_nxt;
      sqx_r <= c0_r.mx * c0_r.mx;
      sqy_r <= c0_r.my * c0_r.my;
      c1_r  <= c0_r;
      sum_r <= sqx_r + sqy_r;
      c2_r  <= c1_r;
    end
  end

  always_comb begin
    sq_st[0].s    = sum_r;
    sq_st[0].rem  = '0;
    sq_st[0].root = '0;
    sq_st[0].c    = c2_r;
    sq_v[0]       = v2_r;
  end

  for (genvar i = 0; i < LEN_W; i++) begin : g_sqrt
    vn_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .i_valid (sq_v[i]),
      .i_st    (sq_st[i]),
      .o_valid (sq_v[i+1]),
      .o_st    (sq_st[i+1])
    );
  end

  always_comb begin
    dv_st[0].len = sq_st[LEN_W].root;
    dv_st[0].rx  = {1'b0, sq_st[LEN_W].c.mx};
    dv_st[0].ry  = {1'b0, sq_st[LEN_W].c.my};
    dv_st[0].qx  = '0;
    dv_st[0].qy  = '0;
    dv_st[0].nx  = sq_st[LEN_W].c.nx;
    dv_st[0].ny  = sq_st[LEN_W].c.ny;
    dv_v[0]      = sq_v[LEN_W];
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    vn_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .i_valid (dv_v[j]),
      .i_st    (dv_st[j]),
      .o_valid (dv_v[j+1]),
      .o_st    (dv_st[j+1])
    );
  end

  always_comb begin
    qx_ext   = {{(OUT_W-Q_W){1'b0}}, dv_st[Q_W].qx};
    qy_ext   = {{(OUT_W-Q_W){1'b0}}, dv_st[Q_W].qy};
    zero_len = dv_st[Q_W].len == '0;
    if (zero_len) begin
      ux_nxt = '0;
      uy_nxt = '0;
    end else begin
      ux_nxt = dv_st[Q_W].nx ? (~qx_ext + 1'b1) : qx_ext;
      uy_nxt = dv_st[Q_W].ny ? (~qy_ext + 1'b1) : qy_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ux_r <= ux_nxt;
      uy_r <= uy_nxt;
      zl_r <= zero_len;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {uy_r, ux_r};
  assign out_tuser  = zl_r;

  `VN_ASSERT_IMP(a_zero_gives_zero, out_valid_r && zl_r, (ux_r == '0) && (uy_r == '0))
  `VN_ASSERT_IMP(a_unit_range, out_valid_r && !zl_r,
    ($signed(ux_r) <= $signed(OUT_W'(1) << FRAC_OUT)) &&
    ($signed(ux_r) >= -$signed(OUT_W'(1) << FRAC_OUT)))
  `VN_ASSERT_NEXT(a_stall_holds_pipe, !adv, $stable(dv_v[Q_W]) && $stable(sq_v[LEN_W]))
endmodule
`default_nettype wire

[dv/testbench.sv]
`default_nettype none
module testbench;
  import vn_pkg::*;

  localparam int PIPE_LAT  = 3 + COMP_BITS + FRAC_OUT + 2;
  localparam int MAX_CYCLE = 1000000;

  typedef struct {
    logic [OUT_W-1:0] ux;
    logic [OUT_W-1:0] uy;
    logic             zl;
  } unit_vec_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [2*OUT_W-1:0] in_tdata;   // comp_x, comp_y
  logic out_tvalid;
  logic out_tready;
  logic [2*OUT_W-1:0] out_tdata;  // unit_x, unit_y
  logic out_tuser;                // zero_length

  unit_vec_t unit_q[$];
  int errors = 0;
  int cycles = 0;
  int out_idle;
  bit hold_req;
  bit hold_out;
  bit rand_out;

  vector2_normalize u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic unit_vec_t normalize(logic [31:0] cx, logic [31:0] cy);
    unit_vec_t r;
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] len;
    logic [63:0] q;
    mx = cx[31] ? (64'd1 << 32) - {32'd0, cx} : {32'd0, cx};
    my = cy[31] ? (64'd1 << 32) - {32'd0, cy} : {32'd0, cy};
    len = isqrt(mx * mx + my * my);
    if (len == 0) begin
      r.ux = 0; r.uy = 0; r.zl = 1'b1;
      return r;
    end
    q = (mx << FRAC_OUT) / len;
    r.ux = cx[31] ? 32'(64'd0 - q) : q[31:0];
    q = (my << FRAC_OUT) / len;
    r.uy = cy[31] ? 32'(64'd0 - q) : q[31:0];
    r.zl = 1'b0;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Offers one vector, waits for its transaction, then idles for the gap.
  task automatic send_vec(logic [31:0] cx, logic [31:0] cy, int gap);
    in_tvalid <= 1'b1;
    in_tdata  <= {cy, cx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    unit_q.push_back(normalize(cx, cy));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_all();
    in_tvalid <= 1'b0;
    while (unit_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] v[10];
    v = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h8000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555, 32'h0000_0003};
    send_vec(0, 0, 0);
    for (int i = 0; i < 5; i++) begin
      send_vec(v[i * 2], 0, 0);
      send_vec(0, v[i * 2 + 1], 1);
      send_vec(v[i * 2], v[i * 2 + 1], 0);
    end
    send_vec(32'h8000_0000, 32'h8000_0000, 0);
    send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_vec(32'h7FFF_FFFF, 32'h8000_0000, 0);
    drain_all();
  endtask

  function automatic logic [31:0] rand_comp();
    int p;
    p = $urandom_range(0, 9);
    if (p < 5) return $urandom();
    if (p < 7) return 32'($signed($urandom_range(0, 200)) - 100);
    if (p < 8) return $urandom() >> $urandom_range(0, 31);
    if (p < 9) return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom())};
    return 0;
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_vec(rand_comp(), rand_comp(), gap_len());
    drain_all();
  endtask

  // The receiver holds off long enough that the pipeline fills and stalls the sender.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 150; i++) send_vec(rand_comp(), rand_comp(), 0);
    drain_all();
  endtask

  initial begin : hold_proc
    hold_out = 1'b0;
    wait (hold_req);
    hold_out = 1'b1;
    repeat (300) @(posedge clk);
    hold_out = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_idle   <= 0;
    end else if (hold_out) begin
      out_tready <= 1'b0;
    end else if (!rand_out) begin
      out_tready <= 1'b1;
    end else if (out_idle > 0) begin
      out_tready <= 1'b0;
      out_idle   <= out_idle - 1;
    end else begin
      out_tready <= 1'b1;
      out_idle   <= gap_len();
    end
  end

  always @(posedge clk) begin
    unit_vec_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (unit_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h %b", out_tdata, out_tuser);
      end else begin
        e = unit_q.pop_front();
        if (out_tdata[31:0] !== e.ux || out_tdata[63:32] !== e.uy || out_tuser !== e.zl) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp x=%h y=%h z=%b got x=%h y=%h z=%b",
                     e.ux, e.uy, e.zl, out_tdata[31:0], out_tdata[63:32], out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    hold_req = 1'b0;
    rand_out = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400);
    rand_out = 1'b1;
    test_random(1100);
    test_backpressure();
    test_random(200);
    rand_out = 1'b0;
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
